### rtl/core/assert_macros.svh
// Assertion macros shared by the traffic light sequencer RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge while the block is out of reset.
`define TLS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define TLS_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tls_pkg.sv
// Package for the traffic light sequencer: state, lamp and dwell types,
// the fixed transition table and the per-state output decode. No dependencies.
package tls_pkg;

	// State numbering and the sensor word.
	localparam int NumStates = 26;
	typedef logic [4:0] state_t;
	typedef logic [2:0] sensors_t;
	typedef logic [15:0] dwell_t;
	typedef logic [2:0] lamp_t;
	typedef logic [2:0] walk_t;

	localparam state_t StateGreenSouth = 5'd0;

	// Lamp codes for the south and west heads.
	localparam lamp_t LampGreen  = 3'd1;
	localparam lamp_t LampYellow = 3'd2;
	localparam lamp_t LampRed    = 3'd4;

	// Walk light colors, RGB with bit0 blue, bit1 red, bit2 green.
	localparam walk_t WalkOff   = 3'd0;
	localparam walk_t WalkRed   = 3'd2;
	localparam walk_t WalkWhite = 3'd7;

	// Configuration register indexes.
	typedef logic [3:0] cfg_index_t;
	localparam cfg_index_t CfgShortDwell = 4'd0;
	localparam cfg_index_t CfgHoldDwell  = 4'd1;
	localparam cfg_index_t CfgFlashDwell = 4'd2;
	localparam cfg_index_t CfgWalkDwell  = 4'd3;

	// Reset values of the dwell registers, in milliseconds.
	localparam dwell_t ShortDwellReset = 16'd1;
	localparam dwell_t HoldDwellReset  = 16'd1500;
	localparam dwell_t FlashDwellReset = 16'd1000;
	localparam dwell_t WalkDwellReset  = 16'd2500;

	// Which dwell register a state loads on entry.
	typedef enum logic [1:0] {
		DW_SHORT = 2'd0,
		DW_HOLD  = 2'd1,
		DW_FLASH = 2'd2,
		DW_WALK  = 2'd3
	} dwell_class_t;

	// The four dwell registers as one group.
	typedef struct packed {
		dwell_t short_ms;
		dwell_t hold_ms;
		dwell_t flash_ms;
		dwell_t walk_ms;
	} dwell_cfg_t;

	// Lamps and dwell class of one state.
	typedef struct packed {
		lamp_t        south;
		lamp_t        west;
		walk_t        walk;
		dwell_class_t dwell;
	} state_out_t;

	// Result of one tick as computed by the step logic.
	typedef struct packed {
		state_t state;
		dwell_t dwell_left;
		logic   moved;
		lamp_t  south;
		lamp_t  west;
		walk_t  walk;
	} step_result_t;

	// Next state, indexed by current state and then by the sensor word.
	localparam state_t NEXT_TAB [NumStates][8] = '{
		'{5'd0,  5'd1,  5'd1,  5'd1,  5'd0,  5'd1,  5'd1,  5'd1 },
		'{5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2 },
		'{5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3 },
		'{5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4 },
		'{5'd0,  5'd7,  5'd6,  5'd7,  5'd5,  5'd7,  5'd6,  5'd7 },
		'{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 },
		'{5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10},
		'{5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8 },
		'{5'd9,  5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9 },
		'{5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15},
		'{5'd11, 5'd11, 5'd10, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11},
		'{5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12},
		'{5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13},
		'{5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14},
		'{5'd5,  5'd7,  5'd25, 5'd7,  5'd5,  5'd5,  5'd5,  5'd5 },
		'{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
		'{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17},
		'{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
		'{5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19},
		'{5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20},
		'{5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21},
		'{5'd22, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22},
		'{5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23},
		'{5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24},
		'{5'd0,  5'd8,  5'd10, 5'd10, 5'd0,  5'd0,  5'd0,  5'd10},
		'{5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10}
	};

	// Lamps and dwell class of each state. Codes past the last state decode as state 0.
	function automatic state_out_t state_out(state_t s);
		state_out_t o;
		o = '{south: LampRed, west: LampRed, walk: WalkRed, dwell: DW_SHORT};
		unique case (s)
			5'd1:  begin o.south = LampGreen;  o.dwell = DW_HOLD; end
			5'd2:  begin o.south = LampYellow; end
			5'd3:  begin o.south = LampYellow; o.dwell = DW_HOLD; end
			5'd4:  begin end
			5'd5, 5'd6, 5'd7, 5'd24, 5'd25: begin o.dwell = DW_HOLD; end
			5'd8:  begin o.walk = WalkWhite; end
			5'd9:  begin o.walk = WalkWhite; o.dwell = DW_WALK; end
			5'd10: begin o.west = LampGreen; end
			5'd11: begin o.west = LampGreen; o.dwell = DW_HOLD; end
			5'd12: begin o.west = LampYellow; end
			5'd13: begin o.west = LampYellow; o.dwell = DW_HOLD; end
			5'd14, 5'd15, 5'd19, 5'd23: begin end
			5'd16, 5'd20: begin o.dwell = DW_FLASH; end
			5'd17, 5'd21: begin o.walk = WalkOff; end
			5'd18, 5'd22: begin o.walk = WalkOff; o.dwell = DW_FLASH; end
			default: begin o.south = LampGreen; end
		endcase
		return o;
	endfunction

endpackage

### rtl/core/tls_step.sv
// Combinational step of the traffic light sequencer: dwell countdown,
// table transition and lamp decode for one tick. Depends on tls_pkg.
module tls_step (
	input  tls_pkg::state_t       state,
	input  tls_pkg::dwell_t       dwell_left,
	input  tls_pkg::sensors_t     sensors,
	input  tls_pkg::dwell_cfg_t   dwell_cfg,
	output tls_pkg::step_result_t result
);
	import tls_pkg::*;

	state_t     cur;
	state_t     nxt;
	state_out_t dec;
	dwell_t     load;
	logic       sample;

	// A state code past the table behaves like green south.
	assign cur = (state < 5'(NumStates)) ? state : StateGreenSouth;

	// The sensors are sampled only once the countdown has run out.
	assign sample = (dwell_left == '0);
	assign nxt    = sample ? NEXT_TAB[cur][sensors] : cur;
	assign dec    = state_out(nxt);

	// Pick the dwell register of the state being entered.
	always_comb begin
		unique case (dec.dwell)
			DW_HOLD:  load = dwell_cfg.hold_ms;
			DW_FLASH: load = dwell_cfg.flash_ms;
			DW_WALK:  load = dwell_cfg.walk_ms;
			default:  load = dwell_cfg.short_ms;
		endcase
	end

	// The tick of entry counts as the first millisecond; a zero register acts as one.
	always_comb begin
		result.state = nxt;
		result.moved = sample && (nxt != cur);
		result.south = dec.south;
		result.west  = dec.west;
		result.walk  = dec.walk;
		if (sample) begin
			result.dwell_left = (load == '0) ? '0 : load - 16'd1;
		end else begin
			result.dwell_left = dwell_left - 16'd1;
		end
	end

endmodule

### rtl/core/traffic_light_sequencer.sv
// Traffic light sequencer: one request is one millisecond tick with three sensor bits.
// The result of an accepted request is written into the output register in the next cycle.
// One request is taken per cycle while in_stall is low; in_stall rises while a held result is stalled.
// Reset clears the state to green south with an empty countdown, loads the dwell
// registers with their defaults and empties the output register. Depends on tls_pkg.
module traffic_light_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  tls_pkg::cfg_index_t  cfg_index,
	input  tls_pkg::dwell_t      cfg_data,
	// Tick request channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tls_pkg::sensors_t    sensors,
	// Result channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output tls_pkg::lamp_t       south_lamp,
	output tls_pkg::lamp_t       west_lamp,
	output tls_pkg::walk_t       walk_colour,
	output tls_pkg::state_t      state_number,
	output logic                 moved
);
	import tls_pkg::*;

	dwell_cfg_t   dwell_cfg_q;
	state_t       state_q;
	dwell_t       dwell_left_q;
	step_result_t step;
	logic         in_accept;
	logic         out_valid_q;
	lamp_t        south_lamp_q;
	lamp_t        west_lamp_q;
	walk_t        walk_colour_q;
	state_t       state_number_q;
	logic         moved_q;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_cfg_q.short_ms <= ShortDwellReset;
			dwell_cfg_q.hold_ms  <= HoldDwellReset;
			dwell_cfg_q.flash_ms <= FlashDwellReset;
			dwell_cfg_q.walk_ms  <= WalkDwellReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgShortDwell: dwell_cfg_q.short_ms <= cfg_data;
				CfgHoldDwell:  dwell_cfg_q.hold_ms  <= cfg_data;
				CfgFlashDwell: dwell_cfg_q.flash_ms <= cfg_data;
				CfgWalkDwell:  dwell_cfg_q.walk_ms  <= cfg_data;
				default: begin end
			endcase
		end
	end

	// A new request enters whenever the output register is free or being drained.
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	tls_step u_step (
		.state      (state_q),
		.dwell_left (dwell_left_q),
		.sensors    (sensors),
		.dwell_cfg  (dwell_cfg_q),
		.result     (step)
	);

	// Machine state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= StateGreenSouth;
			dwell_left_q <= '0;
		end else if (in_accept) begin
			state_q      <= step.state;
			dwell_left_q <= step.dwell_left;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			south_lamp_q   <= step.south;
			west_lamp_q    <= step.west;
			walk_colour_q  <= step.walk;
			state_number_q <= step.state;
			moved_q        <= step.moved;
		end
	end

	assign out_valid    = out_valid_q;
	assign south_lamp   = south_lamp_q;
	assign west_lamp    = west_lamp_q;
	assign walk_colour  = walk_colour_q;
	assign state_number = state_number_q;
	assign moved        = moved_q;

	// Checks on the sequencer's own logic.
`include "assert_macros.svh"

	`TLS_ASSERT_ALWAYS(a_state_in_range, state_q < 5'(NumStates),
		"state register left the table")
	`TLS_ASSERT_NEXT(a_hold_while_counting, in_accept && (dwell_left_q != '0),
		$stable(state_q), "state changed while the dwell was still counting")
	`TLS_ASSERT_NEXT(a_result_matches_state, in_accept,
		out_valid_q && (state_number_q == state_q), "result state differs from machine state")
	`TLS_ASSERT_NEXT(a_moved_only_on_sample, in_accept && (dwell_left_q != '0),
		!moved_q, "moved flagged on a tick that did not sample")

endmodule
